[src/lse_pkg.sv]
`default_nettype none
package lse_pkg;
  localparam int PIXEL_COUNT_DEF = 41;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [2:0] CFG_MODE     = 3'd0;
  localparam logic [2:0] CFG_BRIGHT   = 3'd1;
  localparam logic [2:0] CFG_RB_PER   = 3'd2;
  localparam logic [2:0] CFG_FADE_PER = 3'd3;
  localparam logic [2:0] CFG_TW_PER   = 3'd4;
  localparam logic [2:0] CFG_TW_COL   = 3'd5;

  localparam logic [2:0] MODE_DARK  = 3'd0;
  localparam logic [2:0] MODE_SOLID = 3'd1;
  localparam logic [2:0] MODE_CYCLE = 3'd2;
  localparam logic [2:0] MODE_RAMP  = 3'd3;
  localparam logic [2:0] MODE_TWINK = 3'd4;
  localparam logic [2:0] MODE_NONE  = 3'd7;

  typedef logic [23:0] rgb_t;

  // colour wheel: three ramps of 85, 85 and 86 steps
  function automatic rgb_t wheel(input logic [7:0] pos);
    logic [7:0] p;
    logic [7:0] t;
    logic [7:0] u;
    p = pos;
    if (p < 8'd85) begin
      t = 8'(p * 3);
      u = 8'd255 - t;
      wheel = {t, u, 8'd0};
    end else if (p < 8'd170) begin
      t = 8'((p - 8'd85) * 3);
      u = 8'd255 - t;
      wheel = {u, 8'd0, t};
    end else begin
      t = 8'((p - 8'd170) * 3);
      u = 8'd255 - t;
      wheel = {8'd0, t, u};
    end
  endfunction
endpackage
`default_nettype wire

[src/lse_if.sv]
`default_nettype none
interface lse_in_if;
  logic       valid;
  logic       ready;
  logic [5:0] pixel_pick;
  modport source (output valid, output pixel_pick, input ready);
  modport sink (input valid, input pixel_pick, output ready);
endinterface

interface lse_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] pixel_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] level;
  logic       frame_end;
  modport source (output valid, output pixel_index, output red, output green, output blue,
                  output level, output frame_end, input ready);
  modport sink (input valid, input pixel_index, input red, input green, input blue,
                input level, input frame_end, output ready);
endinterface
`default_nettype wire

[src/lse_frame_mem.sv]
`default_nettype none
// frame store, one write port, one registered read port
module lse_frame_mem #(
  parameter int PIXEL_COUNT = lse_pkg::PIXEL_COUNT_DEF,
  localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1
) (
  input  wire              clk,
  input  wire              we,
  input  wire [AW-1:0]     waddr,
  input  lse_pkg::rgb_t    wdata,
  input  wire [AW-1:0]     raddr,
  output lse_pkg::rgb_t    rdata
);
  lse_pkg::rgb_t mem [PIXEL_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[src/led_strip_effect_engine_top.sv]
`default_nettype none
// channel | dir | words                       | handshake
// in      | in  | pixel_pick, one per tick    | valid/ready
// out     | out | pixel, PIXEL_COUNT per fire | valid/ready
// cfg     | in  | index + data write          | cfg_we
// A tick word is taken and decided in ST_IDLE. A mode change then runs a sweep
// of PIXEL_COUNT pixels writing zeros; a firing tick runs read-modify-write,
// pixel by pixel (read, then write and present) into the output register.
// Reset is synchronous; valid bits make the store read zero before its first
// sweep.
module led_strip_effect_engine_top #(
  parameter int PIXEL_COUNT = lse_pkg::PIXEL_COUNT_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  lse_in_if.sink                        in_ch,
  lse_out_if.source                     out_ch,
  input  wire                           cfg_we,
  input  wire [lse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire [lse_pkg::CFG_DATA_W-1:0] cfg_data
);
  localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
  localparam logic [AW-1:0] LAST = AW'(PIXEL_COUNT - 1);
  // k*256/PIXEL_COUNT as (k*RECIP)>>12, exact for k < 64
  localparam int RECIP_I = ((1 << 20) + PIXEL_COUNT - 1) / PIXEL_COUNT;
  localparam logic [20:0] RECIP = 21'(RECIP_I);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CLEAR = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2; // issue read for pixel
  localparam logic [2:0] ST_EMIT  = 3'd3; // data back, write and present
  localparam logic [2:0] ST_WAIT  = 3'd4; // never entered; ST_EMIT itself waits while the output is held

  // configuration
  logic [2:0]  mode_cfg_r;
  logic [7:0]  bright_r;
  logic [15:0] rb_per_r, fade_per_r, tw_per_r;
  lse_pkg::rgb_t tw_col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_cfg_r <= 3'd2;
      bright_r   <= 8'd128;
      rb_per_r   <= 16'd50;
      fade_per_r <= 16'd10;
      tw_per_r   <= 16'd200;
      tw_col_r   <= 24'd255;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lse_pkg::CFG_MODE:     mode_cfg_r <= cfg_data[2:0];
        lse_pkg::CFG_BRIGHT:   bright_r   <= cfg_data[7:0];
        lse_pkg::CFG_RB_PER:   rb_per_r   <= cfg_data[15:0];
        lse_pkg::CFG_FADE_PER: fade_per_r <= cfg_data[15:0];
        lse_pkg::CFG_TW_PER:   tw_per_r   <= cfg_data[15:0];
        lse_pkg::CFG_TW_COL:   tw_col_r   <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  // effect state
  logic [2:0]  st_r, st_nxt;
  logic [31:0] clock_r;
  logic [31:0] last_r [4];
  logic [7:0]  solid_r, spread_r, fade_lvl_r;
  logic        fade_up_r;
  logic [1:0]  fade_ch_r;
  logic [2:0]  prior_r;
  logic [2:0]  emode_r;      // mode of the tick being worked
  logic [5:0]  pick_r;
  logic        emit_r;       // tick emits a frame
  logic [AW-1:0] idx_r;      // pixel being written/emitted
  logic [PIXEL_COUNT-1:0] vld_r;
  lse_pkg::rgb_t fill_r;     // fill colour for solid/fade

  // output register
  logic        ov_r, ov_nxt;
  logic [5:0]  oidx_r;
  lse_pkg::rgb_t opix_r;
  logic        oend_r;

  // memory
  logic          we;
  logic [AW-1:0] waddr, raddr;
  lse_pkg::rgb_t wdata, rdata;

  lse_frame_mem #(.PIXEL_COUNT(PIXEL_COUNT)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // tick decision
  logic [2:0]  mode;
  logic [31:0] clk_n;
  logic [31:0] diff;
  logic [1:0]  slot;
  logic [15:0] per;
  logic        fire, changed;
  logic [7:0]  fl_n;
  logic        fu_n;
  logic [1:0]  fc_n;

  always_comb begin
    mode    = (mode_cfg_r > 3'd4) ? lse_pkg::MODE_DARK : mode_cfg_r;
    clk_n   = clock_r + 32'd1;
    changed = mode != prior_r;
    slot    = 2'(mode - 3'd1);
    per     = (mode == lse_pkg::MODE_RAMP) ? fade_per_r :
              (mode == lse_pkg::MODE_TWINK) ? tw_per_r : rb_per_r;
    diff    = clk_n - last_r[slot];
    fire    = (mode == lse_pkg::MODE_DARK) ? changed : (diff >= {16'd0, per});
    fl_n    = fade_up_r ? fade_lvl_r + 8'd1 : fade_lvl_r - 8'd1;
    fu_n    = (fl_n == 8'd254 || fl_n == 8'd0) ? ~fade_up_r : fade_up_r;
    fc_n    = (fl_n == 8'd0) ? ((fade_ch_r == 2'd2) ? 2'd0 : fade_ch_r + 2'd1) : fade_ch_r;
  end

  assign in_ch.ready = (st_r == ST_IDLE) && !ov_r;
  wire take = in_ch.valid && in_ch.ready;

  // pixel colour for the current index; rdata is the stored pixel
  lse_pkg::rgb_t cur_old, new_pix;
  logic [AW-1:0]  kdist;
  logic [AW+20:0] sprod;
  logic [7:0]     spos;
  always_comb begin
    cur_old = vld_r[idx_r] ? rdata : '0;
    // pixel j shows wheel of (P-1-j)*256/P + spread (spread_r already stepped)
    kdist = LAST - idx_r;
    sprod = {21'd0, kdist} * {{AW{1'b0}}, RECIP};
    spos  = sprod[19:12] + spread_r - 8'd1;
    unique case (emode_r)
      lse_pkg::MODE_SOLID, lse_pkg::MODE_RAMP: new_pix = fill_r;
      lse_pkg::MODE_CYCLE: new_pix = lse_pkg::wheel(spos);
      lse_pkg::MODE_TWINK:
        new_pix = (pick_r == 6'(idx_r)) ? ((cur_old == '0) ? tw_col_r : '0) : cur_old;
      default: new_pix = '0;
    endcase
  end

  wire out_free = !ov_r || out_ch.ready;

  always_comb begin
    st_nxt = st_r;
    we     = 1'b0;
    waddr  = idx_r;
    wdata  = new_pix;
    raddr  = idx_r;
    ov_nxt = ov_r;
    if (out_ch.ready) ov_nxt = 1'b0;
    unique case (st_r)
      ST_IDLE:  if (take) st_nxt = changed ? ST_CLEAR : (fire ? ST_READ : ST_IDLE);
      ST_CLEAR: begin
        we = 1'b1; wdata = '0;
        if (idx_r == LAST) st_nxt = emit_r ? ST_READ : ST_IDLE;
      end
      ST_READ:  st_nxt = ST_EMIT;
      ST_EMIT:  if (out_free) begin
        we = 1'b1;
        ov_nxt = 1'b1;
        st_nxt = (idx_r == LAST) ? ST_IDLE : ST_READ;
        raddr = idx_r + AW'(1);
      end
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      clock_r   <= '0;
      for (int k = 0; k < 4; k++) last_r[k] <= '0;
      solid_r   <= '0;
      spread_r  <= '0;
      fade_lvl_r<= '0;
      fade_up_r <= 1'b1;
      fade_ch_r <= '0;
      prior_r   <= lse_pkg::MODE_NONE;
      vld_r     <= '0;
      ov_r      <= 1'b0;
      emit_r    <= 1'b0;
      idx_r     <= '0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      if (we) vld_r[waddr] <= 1'b1;
      unique case (st_r)
        ST_IDLE: if (take) begin
          clock_r <= clk_n;
          prior_r <= mode;
          emode_r <= mode;
          pick_r  <= in_ch.pixel_pick;
          emit_r  <= fire;
          idx_r   <= '0;
          if (fire && mode != lse_pkg::MODE_DARK) last_r[slot] <= clk_n;
          if (fire) begin
            unique case (mode)
              lse_pkg::MODE_SOLID: begin
                fill_r  <= lse_pkg::wheel(solid_r);
                solid_r <= solid_r + 8'd1;
              end
              lse_pkg::MODE_CYCLE: spread_r <= spread_r + 8'd1;
              lse_pkg::MODE_RAMP: begin
                fade_lvl_r <= fl_n; fade_up_r <= fu_n; fade_ch_r <= fc_n;
                fill_r <= (fc_n == 2'd0) ? {fl_n, 16'd0} :
                          (fc_n == 2'd1) ? {8'd0, fl_n, 8'd0} : {16'd0, fl_n};
              end
              default: fill_r <= '0;
            endcase
          end
        end
        ST_CLEAR: idx_r <= (idx_r == LAST) ? '0 : idx_r + AW'(1);
        ST_READ: ;
        ST_EMIT: if (out_free) begin
          oidx_r <= 6'(idx_r);
          opix_r <= new_pix;
          oend_r <= idx_r == LAST;
          idx_r  <= idx_r + AW'(1);
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid       = ov_r;
  assign out_ch.pixel_index = oidx_r;
  assign out_ch.red         = opix_r[23:16];
  assign out_ch.green       = opix_r[15:8];
  assign out_ch.blue        = opix_r[7:0];
  assign out_ch.level       = bright_r - 8'd1;
  assign out_ch.frame_end   = oend_r;
endmodule
`default_nettype wire

[bench/led_strip_effect_engine_top_tb.sv]
`default_nettype none

module led_strip_effect_engine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIXELS     = lse_pkg::PIXEL_COUNT_DEF;
  // Worst-case internal work after the last pixel: a silent clear sweep,
  // with margin.
  localparam int SETTLE_CYC = 200;

  typedef struct {
    bit [5:0] idx;
    bit [7:0] red;
    bit [7:0] green;
    bit [7:0] blue;
    bit [7:0] level;
    bit       last;
  } pixel_word_t;

  // Frame predictor and store of expected pixel words.
  class strip_scoreboard;
    bit [2:0]  mode_reg;
    bit [7:0]  bright_reg;
    bit [15:0] rb_period;
    bit [15:0] fade_period;
    bit [15:0] tw_period;
    bit [23:0] tw_colour;

    bit [31:0] ms_count;
    bit [31:0] fired_at[4];
    bit [7:0]  solid_pos;
    bit [7:0]  spread_pos;
    bit [7:0]  fade_lvl;
    bit        fade_up;
    bit [1:0]  fade_chan;
    bit [2:0]  last_mode;
    bit [23:0] frame[PIXELS];

    pixel_word_t pending_px[$];
    int          errors;

    function new();
      mode_reg    = lse_pkg::MODE_CYCLE;
      bright_reg  = 8'd128;
      rb_period   = 16'd50;
      fade_period = 16'd10;
      tw_period   = 16'd200;
      tw_colour   = 24'd255;
      ms_count    = '0;
      foreach (fired_at[k]) fired_at[k] = '0;
      solid_pos   = '0;
      spread_pos  = '0;
      fade_lvl    = '0;
      fade_up     = 1'b1;
      fade_chan   = '0;
      last_mode   = lse_pkg::MODE_NONE;
      foreach (frame[k]) frame[k] = '0;
      errors      = 0;
    endfunction

    function void set_reg(bit [2:0] idx, bit [23:0] d);
      case (idx)
        lse_pkg::CFG_MODE:     mode_reg    = d[2:0];
        lse_pkg::CFG_BRIGHT:   bright_reg  = d[7:0];
        lse_pkg::CFG_RB_PER:   rb_period   = d[15:0];
        lse_pkg::CFG_FADE_PER: fade_period = d[15:0];
        lse_pkg::CFG_TW_PER:   tw_period   = d[15:0];
        lse_pkg::CFG_TW_COL:   tw_colour   = d;
        default: ;
      endcase
    endfunction

    function bit [23:0] wheel_rgb(bit [7:0] pos);
      int p;
      p = pos;
      if (p < 85) return {8'(p * 3), 8'(255 - p * 3), 8'd0};
      if (p < 170) begin
        p -= 85;
        return {8'(255 - p * 3), 8'd0, 8'(p * 3)};
      end
      p -= 170;
      return {8'd0, 8'(p * 3), 8'(255 - p * 3)};
    endfunction

    function void fill(bit [23:0] c);
      foreach (frame[k]) frame[k] = c;
    endfunction

    function bit due(int slot, bit [15:0] period);
      bit [31:0] diff;
      diff = ms_count - fired_at[slot];
      if (diff < {16'd0, period}) return 1'b0;
      fired_at[slot] = ms_count;
      return 1'b1;
    endfunction

    function void queue_frame();
      pixel_word_t w;
      for (int k = 0; k < PIXELS; k++) begin
        w.idx   = 6'(k);
        w.red   = frame[k][23:16];
        w.green = frame[k][15:8];
        w.blue  = frame[k][7:0];
        w.level = bright_reg - 8'd1;
        w.last  = (k == PIXELS - 1);
        pending_px.push_back(w);
      end
    endfunction

    // One accepted millisecond tick.
    function void note_tick(bit [5:0] pick);
      bit [2:0] m;
      bit       changed;
      m = (mode_reg > lse_pkg::MODE_TWINK) ? lse_pkg::MODE_DARK : mode_reg;
      changed = (m != last_mode);
      ms_count++;
      if (changed) fill('0);
      case (m)
        lse_pkg::MODE_SOLID:
          if (due(0, rb_period)) begin
            fill(wheel_rgb(solid_pos));
            queue_frame();
            solid_pos++;
          end
        lse_pkg::MODE_CYCLE:
          if (due(1, rb_period)) begin
            for (int k = 0; k < PIXELS; k++)
              frame[PIXELS - 1 - k] = wheel_rgb(8'((k * 256) / PIXELS + spread_pos));
            queue_frame();
            spread_pos++;
          end
        lse_pkg::MODE_RAMP:
          if (due(2, fade_period)) begin
            fade_lvl = fade_up ? fade_lvl + 8'd1 : fade_lvl - 8'd1;
            if (fade_lvl == 8'd254 || fade_lvl == 8'd0) fade_up = !fade_up;
            if (fade_lvl == 8'd0) fade_chan = 2'((fade_chan + 1) % 3);
            case (fade_chan)
              2'd0:    fill({fade_lvl, 16'd0});
              2'd1:    fill({8'd0, fade_lvl, 8'd0});
              default: fill({16'd0, fade_lvl});
            endcase
            queue_frame();
          end
        lse_pkg::MODE_TWINK:
          if (due(3, tw_period)) begin
            if (pick < PIXELS) frame[pick] = (frame[pick] == '0) ? tw_colour : '0;
            queue_frame();
          end
        default:
          if (changed) queue_frame();
      endcase
      last_mode = m;
    endfunction

    function void check_pixel(pixel_word_t got);
      pixel_word_t exp_w;
      if (pending_px.size() == 0) begin
        $error("pixel word with none expected: index %0d", got.idx);
        errors++;
        return;
      end
      exp_w = pending_px.pop_front();
      if (got.idx != exp_w.idx) begin
        $error("pixel_index: expected %0d, got %0d", exp_w.idx, got.idx); errors++;
      end
      if (got.red != exp_w.red) begin
        $error("red: expected %0d, got %0d", exp_w.red, got.red); errors++;
      end
      if (got.green != exp_w.green) begin
        $error("green: expected %0d, got %0d", exp_w.green, got.green); errors++;
      end
      if (got.blue != exp_w.blue) begin
        $error("blue: expected %0d, got %0d", exp_w.blue, got.blue); errors++;
      end
      if (got.level != exp_w.level) begin
        $error("level: expected %0d, got %0d", exp_w.level, got.level); errors++;
      end
      if (got.last != exp_w.last) begin
        $error("frame_end: expected %0d, got %0d", exp_w.last, got.last); errors++;
      end
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           cfg_we = 1'b0;
  logic [lse_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [lse_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  lse_in_if  in_ch ();
  lse_out_if out_ch ();

  strip_scoreboard sb = new();

  // hold-off requests from the stimulus, served by the receiver process
  int hold_reqs = 0;
  int hold_served = 0;
  int burst_left = 0;

  led_strip_effect_engine_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Receiver: ready pattern picked at random from four styles; hold-off on request.
  initial begin : receiver
    int style;
    int left;
    int hold;
    style = 0;
    left  = 0;
    hold  = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold == 0 && hold_reqs != hold_served) begin
        hold = 600;
        hold_served++;
      end
      if (left == 0) begin
        style = $urandom_range(0, 3);
        left  = $urandom_range(16, 96);
      end
      left--;
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else begin
        case (style)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 1) == 1);
          2:       out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // Pixel word monitor.
  always @(posedge clk) begin
    pixel_word_t w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      w.idx   = out_ch.pixel_index;
      w.red   = out_ch.red;
      w.green = out_ch.green;
      w.blue  = out_ch.blue;
      w.level = out_ch.level;
      w.last  = out_ch.frame_end;
      sb.check_pixel(w);
    end
  end

  // Offer one tick word; bursts with random gaps between them.
  task automatic send_tick(input bit [5:0] pick);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.pixel_pick <= pick;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_tick(pick);
    burst_left--;
  endtask

  task automatic send_random(input int n);
    repeat (n) send_tick(6'($urandom_range(0, 63)));
  endtask

  // Drain the strip and let the block finish any silent sweep.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(input bit [2:0] idx, input bit [23:0] d);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    sb.set_reg(idx, d);
  endtask

  task automatic write_end();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic bit [15:0] rand_period();
    case ($urandom_range(0, 9))
      0:       return 16'hFFFF;
      1:       return 16'($urandom);
      2:       return 16'd0;
      default: return 16'($urandom_range(1, 4));
    endcase
  endfunction

  initial begin : stimulus
    bit [2:0] m;
    in_ch.valid      = 1'b0;
    in_ch.pixel_pick = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, rainbow cycle not yet due
    send_tick(6'd0);
    send_tick(6'd63);

    // off with brightness zero: one blank frame, level wraps
    settle();
    write_reg(lse_pkg::CFG_MODE, 24'(lse_pkg::MODE_DARK));
    write_reg(lse_pkg::CFG_BRIGHT, 24'd0);
    write_end();
    send_tick(6'd1);
    send_tick(6'd2);

    // unused codes behave as off, nothing emitted
    settle();
    write_reg(lse_pkg::CFG_MODE, 24'd5);
    write_end();
    send_tick(6'd3);
    settle();
    write_reg(lse_pkg::CFG_MODE, 24'd7);
    write_end();
    send_tick(6'd4);

    // solid wheel, zero period fires every tick
    settle();
    write_reg(lse_pkg::CFG_MODE, 24'(lse_pkg::MODE_SOLID));
    write_reg(lse_pkg::CFG_RB_PER, 24'd0);
    write_reg(lse_pkg::CFG_BRIGHT, 24'd255);
    write_end();
    repeat (3) send_tick(6'd5);

    settle();
    write_reg(lse_pkg::CFG_MODE, 24'(lse_pkg::MODE_CYCLE));
    write_reg(lse_pkg::CFG_RB_PER, 24'd1);
    write_end();
    repeat (2) send_tick(6'd6);

    // twinkle: edge picks, out-of-range picks, toggle back off
    settle();
    write_reg(lse_pkg::CFG_MODE, 24'(lse_pkg::MODE_TWINK));
    write_reg(lse_pkg::CFG_TW_PER, 24'd0);
    write_reg(lse_pkg::CFG_TW_COL, 24'hFFFFFF);
    write_reg(lse_pkg::CFG_BRIGHT, 24'd32);
    write_end();
    send_tick(6'd0);
    send_tick(6'(PIXELS - 1));
    send_tick(6'(PIXELS));
    send_tick(6'd63);
    send_tick(6'd0);
    settle();
    write_reg(lse_pkg::CFG_TW_COL, 24'd0);
    write_end();
    send_tick(6'd7);

    // fade: longest period never fires, then every tick
    settle();
    write_reg(lse_pkg::CFG_MODE, 24'(lse_pkg::MODE_RAMP));
    write_reg(lse_pkg::CFG_FADE_PER, 24'hFFFF);
    write_end();
    repeat (2) send_tick(6'd8);
    settle();
    write_reg(lse_pkg::CFG_FADE_PER, 24'd0);
    write_end();
    repeat (3) send_tick(6'd9);

    // Fade run with a frame per tick; the receiver holds off meanwhile so
    // the block backs up onto its input.
    hold_reqs++;
    send_random(90);

    // Random settings and ticks
    for (int ph = 0; ph < 5; ph++) begin
      settle();
      m = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      write_reg(lse_pkg::CFG_MODE, 24'(m));
      write_reg(lse_pkg::CFG_BRIGHT, ($urandom_range(0, 7) == 0) ? 24'($urandom_range(0, 31))
                                                                  : 24'($urandom_range(32, 255)));
      write_reg(lse_pkg::CFG_RB_PER, 24'(rand_period()));
      write_reg(lse_pkg::CFG_FADE_PER, 24'(rand_period()));
      write_reg(lse_pkg::CFG_TW_PER, 24'(rand_period()));
      write_reg(lse_pkg::CFG_TW_COL, 24'($urandom));
      write_end();
      if (ph == 3) begin
        // sender waits for the strip to drain mid-phase
        send_random(10);
        settle();
        send_random(12);
      end else begin
        send_random($urandom_range(12, 30));
      end
    end

    settle();
    if (sb.errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : watchdog
    #40ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

`default_nettype wire
